// ===== sv/tagged_byte_packet_deframer_macros.svh =====
// Assertion macros for the tagged byte packet deframer.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TAGGED_BYTE_PACKET_DEFRAMER_MACROS_SVH
`define TAGGED_BYTE_PACKET_DEFRAMER_MACROS_SVH

// Condition must never hold outside reset.
`define TBPD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tbpd: forbidden condition seen");

// Trigger implies the consequence in the next cycle.
`define TBPD_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("tbpd: expected follow-up missing");

`endif

// ===== sv/tbpd_pkg.sv =====
// Shared types and constants for the tagged byte packet deframer.
// No dependencies.
package tbpd_pkg;

  localparam int MAX_PACKET_LEN_DEF = 64;

  localparam logic [7:0]  MARK_STAMP_HI = 8'hC8;
  localparam logic [7:0]  MARK_STAMP_LO = 8'hC9;
  localparam logic [7:0]  MARK_CAP_CLR  = 8'hC5;
  localparam logic [7:0]  MARK_CAP_WORD = 8'hC6;
  localparam logic [7:0]  MARK_SKIP_A   = 8'hC1;
  localparam logic [7:0]  MARK_SKIP_B   = 8'hC2;
  localparam logic [15:0] FRAME_SYNC    = 16'hFFFF;

  localparam logic [1:0]  KIND_WORD  = 2'd0;
  localparam logic [1:0]  KIND_STAMP = 2'd1;
  localparam logic [1:0]  KIND_DIFF  = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_STAMP,
    OP_DIFF
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] val;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_HEAD,
    B_LEN,
    B_XOR,
    B_EMIT
  } back_state_t;

endpackage

// ===== sv/tbpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tbpd_front.sv =====
// Front end: byte tag sequencing, word assembly, word counting and control markers.
// Depends on tbpd_pkg; pushes actions into the decoupling queue.
module tbpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               q_push,
  output tbpd_pkg::q_entry_t q_data,
  input  logic               q_full
);

  logic [1:0]  exp_tag_r, exp_tag_nxt;
  logic [17:0] partial_r, partial_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] stamp_hi_r, stamp_hi_nxt;
  logic        stamp_v_r, stamp_v_nxt;
  logic [2:0]  cap_idx_r, cap_idx_nxt;
  logic [15:0] cap_r [4];
  logic        cap_we;

  logic        accept;
  logic [1:0]  tag;
  logic [5:0]  payload;
  logic [23:0] word;
  logic [7:0]  marker;
  logic [15:0] low;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign tag      = in_byte[7:6];
  assign payload  = in_byte[5:0];
  assign word     = {partial_r, payload};
  assign marker   = word[23:16];
  assign low      = word[15:0];

  always_comb begin
    exp_tag_nxt  = exp_tag_r;
    partial_nxt  = partial_r;
    total_nxt    = total_r;
    stamp_hi_nxt = stamp_hi_r;
    stamp_v_nxt  = stamp_v_r;
    cap_idx_nxt  = cap_idx_r;
    cap_we       = 1'b0;
    q_push       = 1'b0;
    q_data.op    = tbpd_pkg::OP_PUSH;
    q_data.val   = {16'd0, low};
    if (accept) begin
      if (tag == 2'd0) begin
        partial_nxt = {12'd0, payload};
        exp_tag_nxt = 2'd1;
      end else if (tag == exp_tag_r) begin
        partial_nxt = {partial_r[11:0], payload};
        if (tag == 2'd3) begin
          exp_tag_nxt = 2'd0;
          total_nxt   = total_r + 32'd1;
          if (word[23:22] == 2'd3) begin
            unique case (marker) inside
              tbpd_pkg::MARK_STAMP_HI: begin
                stamp_hi_nxt = low;
                stamp_v_nxt  = 1'b1;
              end
              tbpd_pkg::MARK_STAMP_LO: begin
                if (stamp_v_r) begin
                  q_push      = 1'b1;
                  q_data.op   = tbpd_pkg::OP_STAMP;
                  q_data.val  = {stamp_hi_r, low};
                  stamp_v_nxt = 1'b0;
                end
              end
              tbpd_pkg::MARK_CAP_CLR: cap_idx_nxt = 3'd0;
              tbpd_pkg::MARK_CAP_WORD: begin
                if (cap_idx_r < 3'd4) begin
                  cap_we      = 1'b1;
                  cap_idx_nxt = cap_idx_r + 3'd1;
                  if (cap_idx_r == 3'd3) begin
                    // Fourth word completes the capture: report the difference.
                    q_push     = 1'b1;
                    q_data.op  = tbpd_pkg::OP_DIFF;
                    q_data.val = {cap_r[0], cap_r[1]} - {cap_r[2], low} - total_nxt;
                  end
                end
              end
              tbpd_pkg::MARK_SKIP_A, tbpd_pkg::MARK_SKIP_B: ;
              default: q_push = 1'b1;
            endcase
          end
        end else begin
          exp_tag_nxt = tag + 2'd1;
        end
      end else begin
        exp_tag_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_tag_r  <= 2'd0;
      partial_r  <= 18'd0;
      total_r    <= 32'd0;
      stamp_hi_r <= 16'd0;
      stamp_v_r  <= 1'b0;
      cap_idx_r  <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= 16'd0;
      end
    end else begin
      exp_tag_r  <= exp_tag_nxt;
      partial_r  <= partial_nxt;
      total_r    <= total_nxt;
      stamp_hi_r <= stamp_hi_nxt;
      stamp_v_r  <= stamp_v_nxt;
      cap_idx_r  <= cap_idx_nxt;
      if (cap_we) begin
        cap_r[cap_idx_r[1:0]] <= low;
      end
    end
  end

endmodule

// ===== sv/tbpd_queue.sv =====
// Two-entry action queue between the front end and the packet back end.
// Depends on tbpd_pkg for the entry type.
module tbpd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tbpd_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output tbpd_pkg::q_entry_t pop_data,
  output logic               empty
);

  tbpd_pkg::q_entry_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/tbpd_back.sv =====
// Back end: frame buffer, packet scan sequencer and output register.
// Depends on tbpd_pkg and tbpd_ram.
module tbpd_back #(
  parameter int MAX_PACKET_LEN = tbpd_pkg::MAX_PACKET_LEN_DEF,
  parameter int DEPTH          = MAX_PACKET_LEN + 1,
  parameter int RAM_D          = 1 << $clog2(DEPTH),
  parameter int AW             = $clog2(RAM_D),
  parameter int FW             = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  tbpd_pkg::q_entry_t q_data,
  output logic               q_pop,
  output logic [FW-1:0]      fill,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [31:0]        out_result_value,
  output logic               out_is_last
);

  localparam logic [8:0] MAX_LEN9 = 9'(MAX_PACKET_LEN);

  tbpd_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [15:0]   par_r, par_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    kind_r;
  logic [31:0]   value_r;
  logic          last_r;

  logic          load;
  logic [1:0]    ld_kind;
  logic [31:0]   ld_value;
  logic          ld_last;
  logic          out_can;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   rdata;
  logic [15:0]   par_step;
  logic [8:0]    len_in9, len_r9p1;

  tbpd_ram #(.WIDTH(16), .DEPTH(RAM_D), .AW(AW)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_data.val[15:0]),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_can  = !out_valid_r || !out_stall;
  assign par_step = par_r ^ rdata;
  assign len_in9  = {1'b0, rdata[7:0]};
  assign len_r9p1 = {1'b0, len_r} + 9'd1;
  assign fill     = fill_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    par_nxt   = par_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = head_r + AW'(fill_r);
    re        = 1'b0;
    raddr     = head_r;
    load      = 1'b0;
    ld_kind   = tbpd_pkg::KIND_WORD;
    ld_value  = q_data.val;
    ld_last   = 1'b1;
    unique case (state_r)
      tbpd_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_data.op == tbpd_pkg::OP_PUSH) begin
            q_pop     = 1'b1;
            we        = 1'b1;
            fill_nxt  = fill_r + FW'(1);
            state_nxt = tbpd_pkg::B_SCAN;
          end else if (out_can) begin
            q_pop   = 1'b1;
            load    = 1'b1;
            ld_kind = (q_data.op == tbpd_pkg::OP_STAMP) ? tbpd_pkg::KIND_STAMP
                                                        : tbpd_pkg::KIND_DIFF;
          end
        end
      end
      tbpd_pkg::B_SCAN: begin
        if (fill_r == '0) begin
          state_nxt = tbpd_pkg::B_IDLE;
        end else begin
          re        = 1'b1;
          state_nxt = tbpd_pkg::B_HEAD;
        end
      end
      tbpd_pkg::B_HEAD: begin
        if (rdata == tbpd_pkg::FRAME_SYNC) begin
          if (fill_r < FW'(2)) begin
            state_nxt = tbpd_pkg::B_IDLE;
          end else begin
            re        = 1'b1;
            raddr     = head_r + AW'(1);
            state_nxt = tbpd_pkg::B_LEN;
          end
        end else begin
          head_nxt  = head_r + AW'(1);
          fill_nxt  = fill_r - FW'(1);
          state_nxt = tbpd_pkg::B_SCAN;
        end
      end
      tbpd_pkg::B_LEN: begin
        if (len_in9 >= 9'd2 && len_in9 <= MAX_LEN9) begin
          if (9'(fill_r) < len_in9 + 9'd1) begin
            state_nxt = tbpd_pkg::B_IDLE;
          end else begin
            idx_nxt   = 8'd1;
            len_nxt   = rdata[7:0];
            par_nxt   = 16'd0;
            re        = 1'b1;
            raddr     = head_r + AW'(1);
            state_nxt = tbpd_pkg::B_XOR;
          end
        end else begin
          head_nxt  = head_r + AW'(1);
          fill_nxt  = fill_r - FW'(1);
          state_nxt = tbpd_pkg::B_SCAN;
        end
      end
      tbpd_pkg::B_XOR: begin
        if (idx_r == len_r) begin
          if (par_step == 16'd0) begin
            idx_nxt   = 8'd1;
            re        = 1'b1;
            raddr     = head_r + AW'(1);
            state_nxt = tbpd_pkg::B_EMIT;
          end else begin
            head_nxt  = head_r + AW'(1);
            fill_nxt  = fill_r - FW'(1);
            state_nxt = tbpd_pkg::B_SCAN;
          end
        end else begin
          par_nxt = par_step;
          idx_nxt = idx_r + 8'd1;
          re      = 1'b1;
          raddr   = head_r + idx_r[AW-1:0] + AW'(1);
        end
      end
      tbpd_pkg::B_EMIT: begin
        if (out_can) begin
          load     = 1'b1;
          ld_kind  = tbpd_pkg::KIND_WORD;
          ld_value = {16'd0, rdata};
          ld_last  = (idx_r == len_r - 8'd1);
          if (idx_r == len_r - 8'd1) begin
            // Drop sync, length and body in one step.
            head_nxt  = head_r + AW'(len_r9p1);
            fill_nxt  = fill_r - FW'(len_r9p1);
            state_nxt = tbpd_pkg::B_SCAN;
          end else begin
            idx_nxt = idx_r + 8'd1;
            re      = 1'b1;
            raddr   = head_r + idx_r[AW-1:0] + AW'(1);
          end
        end
      end
      default: state_nxt = tbpd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbpd_pkg::B_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    par_r <= par_nxt;
    if (load) begin
      kind_r  <= ld_kind;
      value_r <= ld_value;
      last_r  <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_result_value = value_r;
  assign out_is_last      = last_r;

endmodule

// ===== sv/tagged_byte_packet_deframer.sv =====
// Tagged byte packet deframer, top level.
// Input: in_valid/in_stall/in_byte, one tagged byte per transfer. Four bytes
// tagged 0,1,2,3 build a 24-bit word; an out-of-order tag drops the partial word.
// Output: out_valid/out_stall with out_result_kind, out_result_value and
// out_is_last: packet words, 32-bit timestamps and lost-word difference reports.
// Throughput: a byte is taken every cycle while the two-entry action queue has
// room. A word that lands in the frame buffer starts the scan sequencer, which
// reads the buffer RAM to drop non-sync heads, check a packet's parity over its
// length and body words, and then send the packet words while the receiver
// accepts them. The queue is not popped until the sequencer is back in idle.
// Reset (synchronous, rst_n low) clears tag tracking, counters, capture state,
// the queue and the buffer fill; buffer contents need no clearing.
// When the receiver stalls, the output register holds its result, the scan
// sequencer waits, the queue fills, and in_stall rises.
// Depends on tbpd_pkg, tbpd_front, tbpd_queue, tbpd_back and the macros header.
`include "tagged_byte_packet_deframer_macros.svh"

module tagged_byte_packet_deframer #(
  parameter int MAX_PACKET_LEN = tbpd_pkg::MAX_PACKET_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_result_value,
  output logic        out_is_last
);

  localparam int DEPTH = MAX_PACKET_LEN + 1;
  localparam int FW    = $clog2(DEPTH + 1);

  logic               q_push, q_full, q_pop, q_empty;
  tbpd_pkg::q_entry_t q_in, q_out;
  logic [FW-1:0]      bk_fill;

  // Front end: assemble words and turn them into queued actions.
  tbpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  // Short queue so the front keeps taking bytes while the back scans.
  tbpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back end: buffer words, find framed packets, drive the output register.
  tbpd_back #(.MAX_PACKET_LEN(MAX_PACKET_LEN)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .fill             (bk_fill),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_is_last      (out_is_last)
  );

  // The front must never push into a full queue.
  `TBPD_NEVER(a_queue_no_overflow, q_push && q_full)
  // A pushed action is visible to the back end on the next cycle.
  `TBPD_NEXT(a_push_lands, q_push, !q_empty)
  // The frame buffer never holds more than one maximal packet.
  `TBPD_NEVER(a_fill_bound, bk_fill > FW'(DEPTH))

endmodule
